/* design/bra_pkg.sv */
// bra_pkg: shared codes and the control/status structs of the bitmap range allocator
// used by bra_ctrl, bra_datapath and bitmap_range_allocator; depends on nothing
package bra_pkg;

    localparam logic [2:0] OP_SET   = 3'd0;
    localparam logic [2:0] OP_FLIP  = 3'd1;
    localparam logic [2:0] OP_TALLY = 3'd2;
    localparam logic [2:0] OP_SCAN  = 3'd3;
    localparam logic [2:0] OP_FIRST = 3'd4;
    localparam logic [2:0] OP_NEXT  = 3'd5;
    localparam logic [2:0] OP_BEST  = 3'd6;
    localparam logic [2:0] OP_BUDDY = 3'd7;

    localparam logic [10:0] SIZE_RESET = 11'd1024;

    typedef enum logic [2:0] {
        NX_SCAN,
        NX_HALVE,
        NX_FILL,
        NX_PREP,
        NX_OUT
    } t_next;

    typedef struct packed {
        logic load;
        logic prep;
        logic halve;
        logic rd;
        logic ex;
        logic post;
        logic wrd;
        logic wex;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_next prep_next;
        t_next post_next;
        logic  halve_done;
        logic  scan_more;
        logic  fill_more;
        logic  out_free;
    } t_stat;

endpackage

/* design/bra_if.sv */
// bra_req_if and bra_rsp_if: valid/ready channels for request and result words
// depends on nothing
interface bra_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [10:0] start_bit;
    logic [10:0] run_length;
    logic        bit_value;
    modport source (output valid, req_type, start_bit, run_length, bit_value, input ready);
    modport sink (input valid, req_type, start_bit, run_length, bit_value, output ready);
endinterface

interface bra_rsp_if;
    logic        valid;
    logic        ready;
    logic [9:0]  position;
    logic        found;
    logic [10:0] tally;
    logic        any_match;
    modport source (output valid, position, found, tally, any_match, input ready);
    modport sink (input valid, position, found, tally, any_match, output ready);
endinterface

/* design/bra_ctrl.sv */
// bra_ctrl: sequencer of the allocator, issues commands to bra_datapath
// depends on bra_pkg
module bra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  bra_pkg::t_stat  i_stat,
    output bra_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_HALVE,
        S_SCAN,
        S_RD,
        S_EX,
        S_POST,
        S_FILL,
        S_WRD,
        S_WEX,
        S_OUT
    } t_state;

    t_state r_state;

    function automatic t_state f_go(input bra_pkg::t_next nx);
        t_state st;
        case (nx)
            bra_pkg::NX_SCAN:  st = S_SCAN;
            bra_pkg::NX_HALVE: st = S_HALVE;
            bra_pkg::NX_FILL:  st = S_FILL;
            bra_pkg::NX_PREP:  st = S_PREP;
            default:           st = S_OUT;
        endcase
        return st;
    endfunction

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_req_valid;
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.halve    = (r_state == S_HALVE);
        o_cmd.rd       = (r_state == S_RD);
        o_cmd.ex       = (r_state == S_EX);
        o_cmd.post     = (r_state == S_POST);
        o_cmd.wrd      = (r_state == S_WRD);
        o_cmd.wex      = (r_state == S_WEX);
        o_cmd.out_load = (r_state == S_OUT) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (i_req_valid) r_state <= S_PREP;
                S_PREP:  r_state <= f_go(i_stat.prep_next);
                S_HALVE: if (i_stat.halve_done) r_state <= S_SCAN;
                S_SCAN:  r_state <= i_stat.scan_more ? S_RD : S_POST;
                S_RD:    r_state <= S_EX;
                S_EX:    r_state <= S_SCAN;
                S_POST:  r_state <= f_go(i_stat.post_next);
                S_FILL:  r_state <= i_stat.fill_more ? S_WRD : S_OUT;
                S_WRD:   r_state <= S_WEX;
                S_WEX:   r_state <= S_FILL;
                S_OUT:   if (i_stat.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/bra_datapath.sv */
// bra_datapath: map memory, bit walker, run tracking and result register
// depends on bra_pkg and the bra_req_if / bra_rsp_if interfaces
module bra_datapath #(
    parameter int MAP_BITS  = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [10:0]     i_cfg_data,
    bra_req_if.sink         i_req,
    bra_rsp_if.source       o_rsp,
    input  bra_pkg::t_cmd   i_cmd,
    output bra_pkg::t_stat  o_stat
);

    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int BI = $clog2(WORD_BITS);
    localparam int WI = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IW = ($clog2(MAP_BITS) + 2 > 13) ? $clog2(MAP_BITS) + 2 : 13;
    localparam logic [IW-1:0] MAP_MAX = IW'(MAP_BITS);

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_wv;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvld;

    logic [10:0]   r_size;
    logic [2:0]    r_op;
    logic [IW-1:0] r_start, r_cnt, r_s, r_idx, r_end, r_run, r_best, r_pos, r_blk;
    logic [IW-1:0] r_tally, r_wcnt;
    logic          r_v, r_have, r_hit, r_second, r_ok, r_wval, r_flip;

    logic          r_ovalid;
    logic [9:0]    r_opos;
    logic          r_ofound;
    logic [10:0]   r_otally;
    logic          r_oany;

    logic [WI-1:0]        widx;
    logic [BI-1:0]        bidx;
    logic [WORD_BITS-1:0] word_q, wword;
    logic                 bit_q, eq;
    logic [IW-1:0]        nrun, nblk, size_ext;
    logic                 ff_op;

    assign widx   = r_idx[BI +: WI];
    assign bidx   = r_idx[BI-1:0];
    assign word_q = r_rvld ? r_rdata : '0;
    assign bit_q  = word_q[bidx];
    assign eq     = (r_idx < r_s) && (bit_q == r_v);
    assign nrun   = eq ? r_run + 1'b1 : '0;
    assign ff_op  = (r_op == bra_pkg::OP_SCAN) || (r_op == bra_pkg::OP_FIRST)
                 || (r_op == bra_pkg::OP_NEXT);
    assign size_ext = IW'(r_size);
    assign nblk   = ((r_blk < r_cnt) ? (r_blk << 1) : r_blk) == '0 ? IW'(1)
                  : ((r_blk < r_cnt) ? (r_blk << 1) : r_blk);

    always_comb begin
        wword = word_q;
        wword[bidx] = r_flip ? ~bit_q : r_wval;
    end

    // decisions taken at the prepare and post steps, and the halve, scan, fill and output status flags
    always_comb begin
        o_stat = '0;
        o_stat.prep_next = bra_pkg::NX_OUT;
        case (r_op)
            bra_pkg::OP_SET:   if (r_start + r_cnt <= r_s) o_stat.prep_next = bra_pkg::NX_FILL;
            bra_pkg::OP_FLIP:  if (r_start < r_s) o_stat.prep_next = bra_pkg::NX_FILL;
            bra_pkg::OP_TALLY: if (r_start + r_cnt <= r_s) o_stat.prep_next = bra_pkg::NX_SCAN;
            bra_pkg::OP_BEST:  if (r_start < r_s) o_stat.prep_next = bra_pkg::NX_SCAN;
            bra_pkg::OP_BUDDY: o_stat.prep_next = bra_pkg::NX_HALVE;
            default: begin
                if (r_start >= r_s) begin
                    if (r_op == bra_pkg::OP_NEXT && !r_second)
                        o_stat.prep_next = bra_pkg::NX_PREP;
                end else if (r_cnt != '0) begin
                    o_stat.prep_next = bra_pkg::NX_SCAN;
                end
            end
        endcase

        o_stat.post_next = bra_pkg::NX_OUT;
        case (r_op)
            bra_pkg::OP_FIRST: if (r_hit) o_stat.post_next = bra_pkg::NX_FILL;
            bra_pkg::OP_NEXT: begin
                if (r_hit) o_stat.post_next = bra_pkg::NX_FILL;
                else if (!r_second) o_stat.post_next = bra_pkg::NX_PREP;
            end
            bra_pkg::OP_BEST:  if (r_have) o_stat.post_next = bra_pkg::NX_FILL;
            bra_pkg::OP_BUDDY: if (r_hit && r_idx + r_cnt <= r_s)
                o_stat.post_next = bra_pkg::NX_FILL;
            default: o_stat.post_next = bra_pkg::NX_OUT;
        endcase

        o_stat.halve_done = !(r_blk > r_cnt);
        case (r_op)
            bra_pkg::OP_TALLY: o_stat.scan_more = r_idx < r_end;
            bra_pkg::OP_BEST:  o_stat.scan_more = r_idx <= r_s;
            bra_pkg::OP_BUDDY: o_stat.scan_more = (r_idx < r_s) && !r_hit;
            default:           o_stat.scan_more = ff_op && (r_idx < r_s) && !r_hit;
        endcase
        o_stat.fill_more = r_wcnt != '0;
        o_stat.out_free  = !r_ovalid || o_rsp.ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd || i_cmd.wrd) begin
            r_rdata <= r_mem[widx];
        end
        if (i_cmd.wex) begin
            r_mem[widx] <= wword;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv   <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_cmd.rd || i_cmd.wrd) r_rvld <= r_wv[widx];
            if (i_cmd.wex) r_wv[widx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= bra_pkg::SIZE_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_size <= i_cfg_data;
            if (i_cmd.out_load) r_ovalid <= 1'b1;
            else if (o_rsp.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_req.req_type;
            r_start  <= IW'(i_req.start_bit);
            r_cnt    <= IW'(i_req.run_length);
            r_v      <= i_req.bit_value;
            r_s      <= (size_ext > MAP_MAX) ? MAP_MAX : size_ext;
            r_second <= 1'b0;
            r_tally  <= '0;
            r_ok     <= 1'b0;
            r_pos    <= '0;
            r_wcnt   <= '0;
        end
        if (i_cmd.prep) begin
            r_idx  <= r_start;
            r_run  <= '0;
            r_have <= 1'b0;
            r_hit  <= 1'b0;
            r_blk  <= r_s;
            r_end  <= r_start + r_cnt;
            r_wval <= r_v;
            r_flip <= (r_op == bra_pkg::OP_FLIP);
            case (r_op)
                bra_pkg::OP_SET: begin
                    r_ok   <= (r_start + r_cnt <= r_s);
                    r_wcnt <= r_cnt;
                end
                bra_pkg::OP_FLIP: begin
                    r_ok   <= (r_start < r_s);
                    r_wcnt <= IW'(1);
                end
                bra_pkg::OP_TALLY: r_ok <= (r_start + r_cnt <= r_s);
                bra_pkg::OP_BEST, bra_pkg::OP_BUDDY: r_ok <= 1'b0;
                default: begin
                    if (r_start >= r_s) begin
                        if (r_op == bra_pkg::OP_NEXT && !r_second) begin
                            r_start  <= '0;
                            r_second <= 1'b1;
                        end
                    end else if (r_cnt == '0) begin
                        // empty run matches at the start bit, nothing to write
                        r_ok  <= 1'b1;
                        r_pos <= r_start;
                    end
                end
            endcase
        end
        if (i_cmd.halve) begin
            if (r_blk > r_cnt) r_blk <= r_blk >> 1;
            else r_blk <= nblk;
            r_idx <= '0;
        end
        if (i_cmd.ex) begin
            case (r_op)
                bra_pkg::OP_TALLY: begin
                    if (bit_q == r_v) r_tally <= r_tally + 1'b1;
                    r_idx <= r_idx + 1'b1;
                end
                bra_pkg::OP_BEST: begin
                    if (eq) begin
                        r_run <= r_run + 1'b1;
                    end else begin
                        if (r_run != '0 && r_run >= r_cnt && (!r_have || r_run < r_best)) begin
                            r_have <= 1'b1;
                            r_best <= r_run;
                            r_pos  <= r_idx - r_run;
                        end
                        r_run <= '0;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                bra_pkg::OP_BUDDY: begin
                    if (eq) r_hit <= 1'b1;
                    else r_idx <= r_idx + r_blk;
                end
                default: begin
                    r_run <= nrun;
                    if (nrun == r_cnt && eq) begin
                        r_hit <= 1'b1;
                        r_pos <= r_idx + 1'b1 - r_cnt;
                    end
                    r_idx <= r_idx + 1'b1;
                end
            endcase
        end
        if (i_cmd.post) begin
            r_wval <= ~r_v;
            r_wcnt <= r_cnt;
            case (r_op)
                bra_pkg::OP_BEST: begin
                    r_ok  <= r_have;
                    r_idx <= r_pos;
                end
                bra_pkg::OP_BUDDY: begin
                    r_ok  <= r_hit && (r_idx + r_cnt <= r_s);
                    r_pos <= r_idx;
                end
                bra_pkg::OP_TALLY: r_ok <= r_ok;
                default: begin
                    r_ok  <= r_hit;
                    r_idx <= r_pos;
                    if (r_op == bra_pkg::OP_NEXT && !r_hit && !r_second) begin
                        r_start  <= '0;
                        r_second <= 1'b1;
                    end
                end
            endcase
        end
        if (i_cmd.wex) begin
            r_idx  <= r_idx + 1'b1;
            r_wcnt <= r_wcnt - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_opos   <= r_ok ? r_pos[9:0] : '0;
            r_ofound <= r_ok;
            r_otally <= r_tally[10:0];
            r_oany   <= r_tally != '0;
        end
    end

    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.position  = r_opos;
    assign o_rsp.found     = r_ofound;
    assign o_rsp.tally     = r_otally;
    assign o_rsp.any_match = r_oany;

endmodule

/* design/bitmap_range_allocator.sv */
// bitmap_range_allocator: top level, joins bra_ctrl and bra_datapath
// depends on bra_pkg, bra_if, bra_ctrl and bra_datapath
//
// One request word is taken at a time. The map is walked one examined bit at a time, each in the steps
// check, read and examine, and each written bit takes a read-modify-write (check, read, write) on the
// single map memory port; a next-fit request may walk the map twice. The map is cleared at reset
// through one valid flag per word, so no clearing pass is needed. A finished result waits in an
// output register while the next request is started.
module bitmap_range_allocator #(
    parameter int MAP_BITS  = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data,
    bra_req_if.sink     i_req,
    bra_rsp_if.source   o_rsp
);

    bra_pkg::t_cmd  cmd;
    bra_pkg::t_stat stat;

    bra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bra_datapath #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while another is in work");

    a_fail_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.position == 10'd0))
        else $error("failed result with non-zero position");

    a_any_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.any_match == (o_rsp.tally != 11'd0)))
        else $error("any_match disagrees with tally");
`endif

endmodule

/* dv/tb_bitmap_range_allocator.sv */
// testbench for bitmap_range_allocator: directed and random requests checked against
// an in-bench bit map predictor; depends on bra_pkg, bra_if and the design files
module tb_bitmap_range_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_BITS   = 1024;
    localparam int IDLE_LIMIT = 100000;

    typedef struct {
        logic [2:0]  op;
        logic [10:0] start_bit;
        logic [10:0] run_length;
        logic        bit_value;
    } t_request;

    typedef struct {
        logic [9:0]  position;
        logic        found;
        logic [10:0] tally;
        logic        any_match;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [10:0] i_cfg_data;

    bra_req_if req_ch ();
    bra_rsp_if rsp_ch ();

    bitmap_range_allocator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    always #4 i_clk = ~i_clk;

    t_request    pending_reqs[$];
    t_outcome    expected_outcomes[$];
    logic        shadow_map[MAP_BITS];
    int unsigned shadow_size;
    int unsigned outstanding;
    int unsigned mismatches;
    int unsigned req_gap;
    int unsigned rsp_stall;
    int unsigned idle_cycles;
    bit          bursty;

    task automatic report(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic bit find_first(input int unsigned from, input int unsigned len,
                                      input logic v, input int unsigned s,
                                      output int unsigned pos);
        int unsigned run;
        run = 0;
        if (from >= s) return 1'b0;
        if (len == 0) begin
            pos = from;
            return 1'b1;
        end
        for (int unsigned i = from; i < s; i++) begin
            run = (shadow_map[i] == v) ? run + 1 : 0;
            if (run == len) begin
                pos = i + 1 - len;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // runs end at any differing bit; shortest qualifying run wins, lowest on a tie
    function automatic bit find_best(input int unsigned from, input int unsigned len,
                                     input logic v, input int unsigned s,
                                     output int unsigned pos);
        int unsigned run;
        int unsigned best;
        bit          have;
        run = 0;
        best = 0;
        have = 1'b0;
        for (int unsigned i = from; i <= s; i++) begin
            if (i < s && shadow_map[i] == v) begin
                run++;
            end else begin
                if (run > 0 && run >= len && (!have || run < best)) begin
                    have = 1'b1;
                    best = run;
                    pos = i - run;
                end
                run = 0;
            end
        end
        return have;
    endfunction

    function automatic bit find_buddy(input int unsigned len, input logic v,
                                      input int unsigned s, output int unsigned pos);
        int unsigned blk;
        int unsigned idx;
        blk = s;
        idx = 0;
        while (blk > len) blk = blk / 2;
        if (blk < len) blk = blk * 2;
        if (blk == 0) blk = 1;
        while (idx < s && shadow_map[idx] != v) idx += blk;
        if (idx >= s || idx + len > s) return 1'b0;
        pos = idx;
        return 1'b1;
    endfunction

    function automatic t_outcome predict_outcome(input t_request r);
        t_outcome    o;
        int unsigned s;
        int unsigned pos;
        int unsigned tally;
        bit          ok;
        s = (shadow_size > MAP_BITS) ? MAP_BITS : shadow_size;
        pos = 0;
        tally = 0;
        ok = 1'b0;
        case (r.op)
            bra_pkg::OP_SET: begin
                if (r.start_bit + r.run_length <= s) begin
                    for (int unsigned i = 0; i < r.run_length; i++)
                        shadow_map[r.start_bit + i] = r.bit_value;
                    ok = 1'b1;
                end
            end
            bra_pkg::OP_FLIP: begin
                if (r.start_bit < s) begin
                    shadow_map[r.start_bit] = ~shadow_map[r.start_bit];
                    ok = 1'b1;
                end
            end
            bra_pkg::OP_TALLY: begin
                if (r.start_bit + r.run_length <= s) begin
                    for (int unsigned i = 0; i < r.run_length; i++)
                        if (shadow_map[r.start_bit + i] == r.bit_value) tally++;
                    ok = 1'b1;
                end
            end
            bra_pkg::OP_SCAN, bra_pkg::OP_FIRST:
                ok = find_first(r.start_bit, r.run_length, r.bit_value, s, pos);
            bra_pkg::OP_NEXT: begin
                ok = find_first(r.start_bit, r.run_length, r.bit_value, s, pos);
                if (!ok) ok = find_first(0, r.run_length, r.bit_value, s, pos);
            end
            bra_pkg::OP_BEST: ok = find_best(r.start_bit, r.run_length, r.bit_value, s, pos);
            default: ok = find_buddy(r.run_length, r.bit_value, s, pos);
        endcase
        if (ok && r.op >= bra_pkg::OP_FIRST)
            for (int unsigned i = 0; i < r.run_length; i++)
                shadow_map[pos + i] = ~r.bit_value;
        if (!ok) pos = 0;
        o.position  = pos[9:0];
        o.found     = ok;
        o.tally     = tally[10:0];
        o.any_match = (tally != 0);
        return o;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_request r;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.req_type <= bra_pkg::OP_SET;
            req_ch.start_bit <= '0;
            req_ch.run_length <= '0;
            req_ch.bit_value <= 1'b0;
            req_gap <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                r.op = req_ch.req_type;
                r.start_bit = req_ch.start_bit;
                r.run_length = req_ch.run_length;
                r.bit_value = req_ch.bit_value;
                expected_outcomes.push_back(predict_outcome(r));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (req_gap > 0) begin
                    req_gap <= req_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    req_ch.req_type <= r.op;
                    req_ch.start_bit <= r.start_bit;
                    req_ch.run_length <= r.run_length;
                    req_ch.bit_value <= r.bit_value;
                    req_ch.valid <= 1'b1;
                    req_gap <= bursty ? $urandom_range(0, 7) : 0;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_outcome    e;
        int unsigned n;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall <= 0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_outcomes.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                e = expected_outcomes.pop_front();
                if (rsp_ch.position !== e.position)
                    report($sformatf("position %0d, want %0d", rsp_ch.position, e.position));
                if (rsp_ch.found !== e.found)
                    report($sformatf("found %0b, want %0b", rsp_ch.found, e.found));
                if (rsp_ch.tally !== e.tally)
                    report($sformatf("tally %0d, want %0d", rsp_ch.tally, e.tally));
                if (rsp_ch.any_match !== e.any_match)
                    report($sformatf("any_match %0b, want %0b", rsp_ch.any_match,
                                     e.any_match));
            end
            if (outstanding > 0) outstanding--;
            n = bursty ? $urandom_range(0, 7) : 0;
            rsp_stall <= n;
            rsp_ch.ready <= (n == 0);
        end else if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ch.ready <= (rsp_stall == 1);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_request(input logic [2:0] op, input int unsigned start_bit,
                                 input int unsigned run_length, input logic v);
        t_request r;
        r.op = op;
        r.start_bit = start_bit[10:0];
        r.run_length = run_length[10:0];
        r.bit_value = v;
        pending_reqs.push_back(r);
        outstanding++;
    endtask

    // sender holds off until every result is back, then the block is idle
    task automatic drain();
        wait (outstanding == 0 && pending_reqs.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_size(input int unsigned value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value[10:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_size = value[10:0];
    endtask

    function automatic logic [2:0] random_op();
        int unsigned k;
        k = $urandom_range(0, 7);
        return k[2:0];
    endfunction

    initial begin
        int unsigned sizes[10];
        int unsigned s;
        int unsigned cnt;
        int unsigned top;
        sizes = '{1024, 0, 1, 5, 17, 64, 96, 128, 2047, 40};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        for (int i = 0; i < MAP_BITS; i++) shadow_map[i] = 1'b0;
        shadow_size = bra_pkg::SIZE_RESET;
        outstanding = 0;
        mismatches = 0;
        bursty = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset size
        queue_request(bra_pkg::OP_SET, 0, 0, 1'b1);
        queue_request(bra_pkg::OP_SET, 1000, 24, 1'b1);
        queue_request(bra_pkg::OP_SET, 1001, 24, 1'b1);
        queue_request(bra_pkg::OP_FLIP, 1023, 0, 1'b0);
        queue_request(bra_pkg::OP_FLIP, 1024, 0, 1'b0);
        queue_request(bra_pkg::OP_TALLY, 0, 1024, 1'b1);
        queue_request(bra_pkg::OP_TALLY, 2047, 2047, 1'b0);
        queue_request(bra_pkg::OP_SCAN, 1024, 4, 1'b0);
        queue_request(bra_pkg::OP_SCAN, 5, 0, 1'b1);
        queue_request(bra_pkg::OP_FIRST, 7, 0, 1'b0);
        queue_request(bra_pkg::OP_FIRST, 990, 10, 1'b1);
        queue_request(bra_pkg::OP_NEXT, 1020, 4, 1'b0);
        queue_request(bra_pkg::OP_NEXT, 1024, 0, 1'b0);
        queue_request(bra_pkg::OP_BEST, 0, 0, 1'b1);
        queue_request(bra_pkg::OP_BEST, 0, 3, 1'b1);
        queue_request(bra_pkg::OP_BEST, 1024, 3, 1'b0);
        queue_request(bra_pkg::OP_BUDDY, 0, 0, 1'b0);
        queue_request(bra_pkg::OP_BUDDY, 0, 1023, 1'b0);
        queue_request(bra_pkg::OP_BUDDY, 2047, 1024, 1'b1);
        queue_request(bra_pkg::OP_SET, 0, 1024, 1'b1);
        queue_request(bra_pkg::OP_NEXT, 1536, 1024, 1'b1);
        queue_request(bra_pkg::OP_TALLY, 0, 1024, 1'b0);
        queue_request(bra_pkg::OP_BUDDY, 0, 2047, 1'b1);
        drain();

        // random phases; most at small sizes to keep the walk short
        for (int p = 1; p < 22; p++) begin
            write_size(sizes[p % 10]);
            s = (shadow_size > MAP_BITS) ? MAP_BITS : shadow_size;
            bursty = (p % 3 != 0);
            top = (s >= 1024) ? 30 : 100;
            for (int n = 0; n < top; n++) begin
                if ($urandom_range(0, 7) == 0) begin
                    queue_request(random_op(), $urandom_range(0, 2047),
                                  $urandom_range(0, 2047), $urandom_range(0, 1));
                end else begin
                    cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, s)
                                                      : $urandom_range(0, (s + 3) / 4);
                    queue_request(random_op(), $urandom_range(0, s), cnt,
                                  $urandom_range(0, 1));
                end
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
